// ===== rtl/lphm_pkg.sv =====
`default_nettype none
package lphm_pkg;

   localparam int TABLE_SLOTS_DEF = 1024;
   localparam int KEY_BITS_DEF    = 64;

   localparam logic [63:0] MM_SEED  = 64'hc800c831bc63dff8;
   localparam logic [63:0] MM_MUL   = 64'hc6a4a7935bd1e995;
   localparam int          MM_SHIFT = 47;

   localparam int VALUE_W = 10;
   localparam int COUNT_W = 11;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_INSERTED  = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic [1:0] REG_KEY_BYTES    = 2'd0;
   localparam logic [1:0] REG_ACTIVE_SLOTS = 2'd1;
   localparam logic [1:0] REG_MAX_ELEMS    = 2'd2;

   localparam logic [3:0]  KEY_BYTES_RST    = 4'd8;
   localparam logic [10:0] ACTIVE_SLOTS_RST = 11'd1024;
   localparam logic [9:0]  MAX_ELEMS_RST    = 10'd768;

endpackage
`default_nettype wire

// ===== rtl/linear_probing_hash_map_top.sv =====
// A request is hashed on one shared 32x32 multiplier (keys under 8 bytes skip the key mix),
// reduced by a bit-serial modulo and probed slot by slot (each slot read, then evaluated);
// the outcome goes to the result register. Remove adds a collision scan, a collision move,
// a repair pass that shifts entries back, and a finish step. Insert when full or an unused
// command goes straight to the result. Throughput: one transaction at a time. Reset and
// key_bytes or active_slots writes clear the slot memory; no request is taken until done.
`default_nettype none
module linear_probing_hash_map_top
   import lphm_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_command,
   input  wire logic [63:0]          req_key,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [VALUE_W-1:0]        rsp_value_slot,
   output logic [COUNT_W-1:0]        rsp_element_count,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [3:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   localparam int SW  = $clog2(TABLE_SLOTS);
   localparam int SLW = $clog2(TABLE_SLOTS + 1);
   localparam int IW  = SLW + 1;
   localparam int MW  = 1 + 2 * SW;
   localparam int TOPB0 = KEY_BITS / 8;
   localparam int TOPB1 = (TOPB0 < 1) ? 1 : TOPB0;
   localparam int TOPB  = (TOPB1 > 8) ? 8 : TOPB1;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_MUL, S_DIV, S_PRD, S_PEV, S_RRD, S_REV,
      S_MV1, S_MV2, S_HSTEP, S_HRD, S_HEV, S_HW2, S_FIN, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      HP_LEN, HP_KEY, HP_MIX, HP_FIN1, HP_FIN2
   } hash_phase_type;

   logic [MW-1:0]       meta_mem [TABLE_SLOTS];
   logic [KEY_BITS-1:0] key_mem  [TABLE_SLOTS];
   logic [MW-1:0]       rmeta_ff;
   logic [KEY_BITS-1:0] rkey_ff;
   logic                mwe, kwe;
   logic [SW-1:0]       mwaddr, kwaddr, raddr;
   logic [MW-1:0]       mwdata;
   logic [KEY_BITS-1:0] kwdata;

   state_type      state_ff, state_in;
   hash_phase_type hp_ff, hp_in;
   logic [1:0]     cmd_ff, cmd_in;
   logic [63:0]    key_ff, key_in;
   logic [1:0]     mstep_ff, mstep_in;
   logic [63:0]    mop_ff, mop_in;
   logic [63:0]    acc_ff, acc_in;
   logic [63:0]    prod_ff;
   logic [63:0]    h_ff, h_in;
   logic [SLW-1:0] rem_ff, rem_in;
   logic [5:0]     dcnt_ff, dcnt_in;
   logic [SW-1:0]  cur_ff, cur_in;
   logic [SLW-1:0] dist_ff, dist_in;
   logic [SW-1:0]  base_ff, base_in;
   logic [SW-1:0]  fh_ff, fh_in;
   logic [IW-1:0]  i_ff, i_in;
   logic [SW-1:0]  hole_ff, hole_in;
   logic [IW-1:0]  gap_ff, gap_in;
   logic [IW-1:0]  steps_ff, steps_in;
   logic [SW-1:0]  clr_ff, clr_in;
   logic [SLW-1:0] count_ff, count_in;
   logic [1:0]     st_ff, st_in;
   logic [SW-1:0]  hv_ff, hv_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [SW-1:0]  rsp_hndl_ff, rsp_hndl_in;
   logic [SLW-1:0] rsp_count_ff, rsp_count_in;

   logic [3:0]  kb_ff;
   logic [10:0] as_ff;
   logic [9:0]  me_ff;

   logic           cfg_wr;
   logic [1:0]     cfg_idx;
   logic [3:0]     bytes;
   logic [SLW-1:0] slots;
   logic [SLW-1:0] limit;
   logic [63:0]    kmask;
   logic [31:0]    mul_a, mul_b;
   logic [63:0]    res, hs, t;
   logic [SLW:0]   dtmp;
   logic [SLW-1:0] rem_new;
   logic           r_occ;
   logic [SW-1:0]  r_dist, r_hndl;

   function automatic logic [SW-1:0] nxt(input logic [SW-1:0] s, input logic [SLW-1:0] n);
      logic [SLW-1:0] v;
      v = SLW'(s) + SLW'(1);
      return (v >= n) ? '0 : SW'(v);
   endfunction

   assign cfg_wr  = psel & penable & pwrite;
   assign cfg_idx = paddr[3:2];
   assign pready  = 1'b1;

   always_comb begin
      unique case (cfg_idx)
         REG_KEY_BYTES:    prdata = 32'(kb_ff);
         REG_ACTIVE_SLOTS: prdata = 32'(as_ff);
         REG_MAX_ELEMS:    prdata = 32'(me_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      logic [31:0] s32, m32;
      priority if (kb_ff < 4'd1) bytes = 4'd1;
      else if (32'(kb_ff) > 32'(TOPB)) bytes = 4'(TOPB);
      else bytes = kb_ff;
      priority if (as_ff < 11'd2) s32 = 32'd2;
      else if (32'(as_ff) > 32'(TABLE_SLOTS)) s32 = 32'(TABLE_SLOTS);
      else s32 = 32'(as_ff);
      slots = SLW'(s32);
      m32 = (me_ff == 10'd0) ? 32'd1 : 32'(me_ff);
      if (m32 > s32 - 32'd1) m32 = s32 - 32'd1;
      limit = SLW'(m32);
      for (int j = 0; j < 8; j++) begin
         kmask[j*8 +: 8] = (4'(j) < bytes) ? 8'hff : 8'h00;
      end
   end

   assign r_occ  = rmeta_ff[MW-1];
   assign r_dist = rmeta_ff[2*SW-1:SW];
   assign r_hndl = rmeta_ff[SW-1:0];

   assign mul_a = (mstep_ff == 2'd2) ? mop_ff[63:32] : mop_ff[31:0];
   assign mul_b = (mstep_ff == 2'd1) ? MM_MUL[63:32] : MM_MUL[31:0];
   assign res   = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (mwe) meta_mem[mwaddr] <= mwdata;
      if (kwe) key_mem[kwaddr] <= kwdata;
      rmeta_ff <= meta_mem[raddr];
      rkey_ff  <= key_mem[raddr];
   end

   always_comb begin
      state_in = state_ff;   hp_in = hp_ff;       cmd_in = cmd_ff;     key_in = key_ff;
      mstep_in = mstep_ff;   mop_in = mop_ff;     acc_in = acc_ff;     h_in = h_ff;
      rem_in = rem_ff;       dcnt_in = dcnt_ff;   cur_in = cur_ff;     dist_in = dist_ff;
      base_in = base_ff;     fh_in = fh_ff;       i_in = i_ff;         hole_in = hole_ff;
      gap_in = gap_ff;       steps_in = steps_ff; clr_in = clr_ff;     count_in = count_ff;
      st_in = st_ff;         hv_in = hv_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_hndl_in   = rsp_hndl_ff;
      rsp_count_in  = rsp_count_ff;
      mwe = 1'b0;  mwaddr = cur_ff;  mwdata = '0;
      kwe = 1'b0;  kwaddr = cur_ff;  kwdata = key_ff[KEY_BITS-1:0];
      raddr = cur_ff;
      hs = MM_SEED ^ res;
      t  = '0;
      dtmp = {rem_ff, h_ff[63]};
      rem_new = (dtmp >= {1'b0, slots}) ? SLW'(dtmp - {1'b0, slots}) : SLW'(dtmp);
      req_ready = (state_ff == S_IDLE);

      unique case (state_ff)
         S_CLR: begin
            mwe = 1'b1;
            mwaddr = clr_ff;
            mwdata = {1'b0, {SW{1'b0}}, clr_ff};
            clr_in = clr_ff + SW'(1);
            if (clr_ff == SW'(TABLE_SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command;
               key_in = req_key & kmask;
               priority if (req_command == CMD_NONE) begin
                  st_in = ST_NOT_FOUND;
                  hv_in = '0;
                  state_in = S_DONE;
               end else if (req_command == CMD_INSERT && count_ff >= limit) begin
                  st_in = ST_FULL;
                  hv_in = '0;
                  state_in = S_DONE;
               end else begin
                  hp_in = HP_LEN;
                  mstep_in = 2'd0;
                  mop_in = 64'(bytes);
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            mstep_in = mstep_ff + 2'd1;
            unique case (mstep_ff)
               2'd0: ;
               2'd1: acc_in = prod_ff;
               2'd2: acc_in[63:32] = acc_ff[63:32] + prod_ff[31:0];
               2'd3: begin
                  unique case (hp_ff)
                     HP_LEN: begin
                        if (bytes >= 4'd8) begin
                           h_in = hs;
                           mop_in = key_ff;
                           hp_in = HP_KEY;
                        end else begin
                           mop_in = hs ^ key_ff;
                           hp_in = HP_FIN1;
                        end
                     end
                     HP_KEY: begin
                        mop_in = res ^ (res >> MM_SHIFT);
                        hp_in = HP_MIX;
                     end
                     HP_MIX: begin
                        mop_in = h_ff ^ res;
                        hp_in = HP_FIN1;
                     end
                     HP_FIN1: begin
                        mop_in = res ^ (res >> MM_SHIFT);
                        hp_in = HP_FIN2;
                     end
                     HP_FIN2: begin
                        t = res ^ (res >> MM_SHIFT);
                        h_in = t;
                        rem_in = '0;
                        dcnt_in = '0;
                        state_in = S_DIV;
                     end
                     default: state_in = S_DIV;
                  endcase
               end
            endcase
         end
         S_DIV: begin
            h_in = {h_ff[62:0], 1'b0};
            rem_in = rem_new;
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd63) begin
               cur_in = SW'(rem_new);
               dist_in = '0;
               state_in = S_PRD;
            end
         end
         S_PRD: state_in = S_PEV;
         S_PEV: begin
            priority if (!r_occ) begin
               if (cmd_ff == CMD_INSERT) begin
                  kwe = 1'b1;
                  mwe = 1'b1;
                  mwdata = {1'b1, SW'(dist_ff), r_hndl};
                  count_in = count_ff + SLW'(1);
                  st_in = ST_INSERTED;
                  hv_in = r_hndl;
               end else begin
                  st_in = ST_NOT_FOUND;
                  hv_in = '0;
               end
               state_in = S_DONE;
            end else if (rkey_ff == key_ff[KEY_BITS-1:0]) begin
               fh_in = r_hndl;
               if (cmd_ff == CMD_REMOVE) begin
                  base_in = r_dist;
                  hole_in = cur_ff;
                  cur_in = nxt(cur_ff, slots);
                  i_in = IW'(1);
                  state_in = S_RRD;
               end else begin
                  st_in = ST_FOUND;
                  hv_in = r_hndl;
                  state_in = S_DONE;
               end
            end else begin
               cur_in = nxt(cur_ff, slots);
               dist_in = dist_ff + SLW'(1);
               if (dist_ff + SLW'(1) >= slots) begin
                  st_in = (cmd_ff == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
                  hv_in = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_PRD;
               end
            end
         end
         S_RRD: state_in = S_REV;
         S_REV: begin
            priority if (i_ff > IW'(1) && (!r_occ || (i_ff - IW'(1)) >= IW'(slots))) begin
               mwe = 1'b1;
               mwaddr = hole_ff;
               mwdata = {1'b0, {SW{1'b0}}, fh_ff};
               cur_in = hole_ff;
               gap_in = '0;
               steps_in = '0;
               state_in = S_HSTEP;
            end else if (IW'(r_dist) == IW'(base_ff) + i_ff) begin
               state_in = S_MV1;
            end else begin
               cur_in = nxt(cur_ff, slots);
               i_in = i_ff + IW'(1);
               state_in = S_RRD;
            end
         end
         S_MV1: begin
            mwe = 1'b1;
            mwaddr = hole_ff;
            mwdata = {1'b1, base_ff, r_hndl};
            kwe = 1'b1;
            kwaddr = hole_ff;
            kwdata = rkey_ff;
            state_in = S_MV2;
         end
         S_MV2, S_HW2: begin
            mwe = 1'b1;
            mwaddr = cur_ff;
            mwdata = {1'b0, {SW{1'b0}}, fh_ff};
            hole_in = cur_ff;
            gap_in = '0;
            if (state_ff == S_MV2) steps_in = '0;
            state_in = S_HSTEP;
         end
         S_HSTEP: begin
            if (steps_ff >= {slots, 1'b0}) begin
               state_in = S_FIN;
            end else begin
               steps_in = steps_ff + IW'(1);
               gap_in = gap_ff + IW'(1);
               cur_in = nxt(cur_ff, slots);
               state_in = S_HRD;
            end
         end
         S_HRD: state_in = S_HEV;
         S_HEV: begin
            priority if (IW'(r_dist) >= gap_ff) begin
               mwe = 1'b1;
               mwaddr = hole_ff;
               mwdata = {1'b1, SW'(IW'(r_dist) - gap_ff), r_hndl};
               kwe = 1'b1;
               kwaddr = hole_ff;
               kwdata = rkey_ff;
               state_in = S_HW2;
            end else if (!r_occ) begin
               state_in = S_FIN;
            end else begin
               state_in = S_HSTEP;
            end
         end
         S_FIN: begin
            if (count_ff != '0) count_in = count_ff - SLW'(1);
            st_in = ST_FOUND;
            hv_in = fh_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = st_ff;
               rsp_hndl_in = hv_ff;
               rsp_count_in = count_ff;
               state_in = S_IDLE;
            end
         end
      endcase

      if (cfg_wr && (cfg_idx == REG_KEY_BYTES || cfg_idx == REG_ACTIVE_SLOTS)) begin
         state_in = S_CLR;
         clr_in = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      hp_ff <= hp_in;       cmd_ff <= cmd_in;       key_ff <= key_in;
      mstep_ff <= mstep_in; mop_ff <= mop_in;       acc_ff <= acc_in;
      h_ff <= h_in;         rem_ff <= rem_in;       dcnt_ff <= dcnt_in;
      cur_ff <= cur_in;     dist_ff <= dist_in;     base_ff <= base_in;
      fh_ff <= fh_in;       i_ff <= i_in;           hole_ff <= hole_in;
      gap_ff <= gap_in;     steps_ff <= steps_in;   st_ff <= st_in;
      hv_ff <= hv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hndl_ff <= rsp_hndl_in;
      rsp_count_ff <= rsp_count_in;
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         kb_ff <= KEY_BYTES_RST;
         as_ff <= ACTIVE_SLOTS_RST;
         me_ff <= MAX_ELEMS_RST;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr) begin
            unique case (cfg_idx)
               REG_KEY_BYTES:    kb_ff <= pwdata[3:0];
               REG_ACTIVE_SLOTS: as_ff <= pwdata[10:0];
               REG_MAX_ELEMS:    me_ff <= pwdata[9:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_value_slot    = VALUE_W'(rsp_hndl_ff);
   assign rsp_element_count = COUNT_W'(rsp_count_ff);

endmodule
`default_nettype wire

// ===== rtl/lphm_checker.sv =====
`default_nettype none
module lphm_checker
   import lphm_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [1:0]         rsp_status,
   input wire logic [VALUE_W-1:0] rsp_value_slot,
   input wire logic [COUNT_W-1:0] rsp_element_count
);

   // held result must not be dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_no_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL)
      |-> rsp_value_slot == '0)
      else $error("handle given without a stored key");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INSERTED |-> rsp_element_count != '0)
      else $error("insert reported with empty table");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while busy");

   a_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

endmodule

bind linear_probing_hash_map_top lphm_checker u_lphm_checker (.*);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
import lphm_pkg::*;

class hash_map_scoreboard;
   logic [3:0]  reg_key_bytes;
   logic [10:0] reg_slots;
   logic [9:0]  reg_limit;
   logic [63:0] keys[1024];
   int unsigned dist_of[1024];
   bit          occ[1024];
   int unsigned handle_of[1024];
   int unsigned count;
   logic [1:0]  exp_status[$];
   logic [9:0]  exp_slot[$];
   logic [10:0] exp_count[$];
   int          mismatches;

   function new();
      reg_key_bytes = KEY_BYTES_RST;
      reg_slots = ACTIVE_SLOTS_RST;
      reg_limit = MAX_ELEMS_RST;
      mismatches = 0;
      wipe();
   endfunction

   function void wipe();
      for (int i = 0; i < 1024; i++) begin
         keys[i] = '0;
         dist_of[i] = 0;
         occ[i] = 0;
         handle_of[i] = i;
      end
      count = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == REG_KEY_BYTES) begin
         reg_key_bytes = val[3:0];
         wipe();
      end else if (idx == REG_ACTIVE_SLOTS) begin
         reg_slots = val[10:0];
         wipe();
      end else if (idx == REG_MAX_ELEMS) begin
         reg_limit = val[9:0];
      end
   endfunction

   function int pending();
      return exp_status.size();
   endfunction

   function logic [63:0] murmur(logic [63:0] k, int unsigned len);
      logic [63:0] h, w;
      h = MM_SEED ^ (64'(len) * MM_MUL);
      if (len >= 8) begin
         w = k * MM_MUL;
         w = w ^ (w >> MM_SHIFT);
         w = w * MM_MUL;
         h = (h ^ w) * MM_MUL;
      end else begin
         h = (h ^ k) * MM_MUL;
      end
      h = h ^ (h >> MM_SHIFT);
      h = h * MM_MUL;
      h = h ^ (h >> MM_SHIFT);
      return h;
   endfunction

   function int unsigned nxt(int unsigned s, int unsigned slots);
      return (s + 1 >= slots) ? 0 : s + 1;
   endfunction

   function void move_entry(int unsigned dst, int unsigned src, int unsigned d);
      int unsigned t;
      t = handle_of[dst];
      handle_of[dst] = handle_of[src];
      handle_of[src] = t;
      keys[dst] = keys[src];
      dist_of[dst] = d;
      occ[dst] = 1;
      occ[src] = 0;
      dist_of[src] = 0;
   endfunction

   function void shift_back(int unsigned hole, int unsigned slots);
      int unsigned steps, gap, cur;
      steps = 0;
      gap = 0;
      cur = hole;
      while (steps < 2 * slots) begin
         steps++;
         gap++;
         cur = nxt(cur, slots);
         if (dist_of[cur] >= gap) begin
            move_entry(hole, cur, dist_of[cur] - gap);
            hole = cur;
            gap = 0;
         end else if (!occ[cur]) begin
            return;
         end
      end
   endfunction

   function void note_command(logic [1:0] cmd, logic [63:0] key);
      int unsigned bytes, slots, limit, home, cur, d, base, scan, i;
      logic [63:0] k;
      logic [1:0]  st;
      int unsigned hnd;
      bit found, free_seen, col;
      bytes = 32'(reg_key_bytes);
      if (bytes < 1) bytes = 1;
      if (bytes > 8) bytes = 8;
      slots = 32'(reg_slots);
      if (slots < 2) slots = 2;
      if (slots > 1024) slots = 1024;
      limit = 32'(reg_limit);
      if (limit < 1) limit = 1;
      if (limit > slots - 1) limit = slots - 1;
      k = (bytes >= 8) ? key : key & ((64'd1 << (bytes * 8)) - 64'd1);
      home = 32'(murmur(k, bytes) % 64'(slots));
      st = ST_NOT_FOUND;
      hnd = 0;
      cur = home;
      d = 0;
      found = 0;
      free_seen = 0;
      if (cmd == CMD_INSERT && count >= limit) begin
         st = ST_FULL;
      end else if (cmd != CMD_NONE) begin
         while (d < slots) begin
            if (!occ[cur]) begin
               free_seen = 1;
               break;
            end
            if (keys[cur] == k) begin
               found = 1;
               break;
            end
            cur = nxt(cur, slots);
            d++;
         end
         if (found) begin
            st = ST_FOUND;
            hnd = handle_of[cur];
            if (cmd == CMD_REMOVE) begin
               base = dist_of[cur];
               scan = nxt(cur, slots);
               i = 0;
               col = 0;
               do begin
                  i++;
                  if (dist_of[scan] == base + i) begin
                     col = 1;
                     break;
                  end
                  scan = nxt(scan, slots);
               end while (occ[scan] && i < slots);
               if (col) begin
                  move_entry(cur, scan, base);
                  shift_back(scan, slots);
               end else begin
                  occ[cur] = 0;
                  dist_of[cur] = 0;
                  shift_back(cur, slots);
               end
               if (count > 0) count--;
            end
         end else if (cmd == CMD_INSERT) begin
            if (free_seen) begin
               keys[cur] = k;
               dist_of[cur] = d;
               occ[cur] = 1;
               count++;
               st = ST_INSERTED;
               hnd = handle_of[cur];
            end else begin
               st = ST_FULL;
            end
         end
      end
      exp_status.push_back(st);
      exp_slot.push_back(hnd[9:0]);
      exp_count.push_back(count[10:0]);
   endfunction

   function void check_response(logic [1:0] st, logic [9:0] vs, logic [10:0] ec);
      logic [1:0]  es;
      logic [9:0]  ev;
      logic [10:0] ecn;
      if (exp_status.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response status=%0d slot=%0d count=%0d", st, vs, ec);
         return;
      end
      es = exp_status.pop_front();
      ev = exp_slot.pop_front();
      ecn = exp_count.pop_front();
      if (st !== es || vs !== ev || ec !== ecn) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp status=%0d slot=%0d count=%0d, got %0d %0d %0d",
                     es, ev, ecn, st, vs, ec);
      end
   endfunction
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_LOOKUP;
   logic [63:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [9:0]  rsp_value_slot;
   logic [10:0] rsp_element_count;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   hash_map_scoreboard sb = new();
   int  send_idle = 29;
   int  recv_idle = 57;
   bit  hold_req = 0;
   bit  hold_seen = 0;
   int  hold_left = 0;
   logic [63:0] pool[64];

   linear_probing_hash_map_top dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (hold_req && !hold_seen) begin
         hold_left <= 600;
         hold_seen <= 1;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_value_slot, rsp_element_count);

   task automatic send(logic [1:0] cmd, logic [63:0] key);
      if ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_key <= key;
      do @(posedge clock); while (!req_ready);
      sb.note_command(cmd, key);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      sb.write_reg(idx, val);
   endtask

   initial begin
      #20ms;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      int kb[10] = '{8, 1, 0, 15, 2, 3, 8, 4, 1, 5};
      int sl[10] = '{1024, 2, 1, 16, 8, 32, 2047, 64, 256, 13};
      int me[10] = '{768, 1, 0, 1023, 7, 20, 1023, 63, 255, 12};
      int cnt[10] = '{120, 60, 60, 130, 150, 150, 90, 150, 150, 100};
      int done_items, npool, r;
      logic [63:0] k;
      logic [1:0] c;
      done_items = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      // directed
      send(CMD_LOOKUP, 64'h0);
      send(CMD_INSERT, 64'h0);
      send(CMD_INSERT, 64'hffff_ffff_ffff_ffff);
      send(CMD_INSERT, 64'h0);
      send(CMD_LOOKUP, 64'hffff_ffff_ffff_ffff);
      send(CMD_REMOVE, 64'h0);
      send(CMD_REMOVE, 64'h0);
      send(CMD_NONE, 64'hffff_ffff_ffff_ffff);
      send(CMD_LOOKUP, 64'h0);
      drain();
      csr_write(REG_KEY_BYTES, 1);
      csr_write(REG_ACTIVE_SLOTS, 2);
      csr_write(REG_MAX_ELEMS, 1);
      send(CMD_INSERT, 64'h55);
      send(CMD_INSERT, 64'h55);
      send(CMD_INSERT, 64'haa);
      send(CMD_LOOKUP, 64'hffff_ff55);
      send(CMD_REMOVE, 64'h55);
      send(CMD_INSERT, 64'haa);
      send(CMD_NONE, 64'haa);
      drain();
      for (int p = 0; p < 10; p++) begin
         csr_write(REG_KEY_BYTES, kb[p]);
         csr_write(REG_ACTIVE_SLOTS, sl[p]);
         csr_write(REG_MAX_ELEMS, me[p]);
         npool = (sl[p] < 20) ? sl[p] + 4 : 64;
         for (int i = 0; i < 64; i++) pool[i] = {$urandom, $urandom};
         for (int n = 0; n < cnt[p]; n++) begin
            if (p == 4 && n == 10) hold_req = 1;
            if (done_items < 400) begin
               send_idle = 29;
               recv_idle = 57;
            end else if (done_items < 800) begin
               send_idle = 57;
               recv_idle = 29;
            end else begin
               send_idle = 0;
               recv_idle = 0;
            end
            r = $urandom_range(0, 99);
            c = (r < 45) ? CMD_INSERT : (r < 75) ? CMD_LOOKUP : (r < 95) ? CMD_REMOVE
                : CMD_NONE;
            if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
            else begin
               k = {$urandom, $urandom};
               r = 8 * ((kb[p] < 1) ? 1 : (kb[p] > 8) ? 8 : kb[p]);
               k = (r == 64) ? pool[$urandom_range(0, npool - 1)]
                   : ((k >> r) << r) | (pool[$urandom_range(0, npool - 1)]
                     & ((64'd1 << r) - 1));
            end
            send(c, k);
            done_items++;
         end
         drain();
      end
      repeat (100) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
